// ===== rtl/tcd_pkg.sv =====
// Shared types and constants for the text cell decoder.
`timescale 1ns / 1ps

package tcd_pkg;

    localparam int ADDR_W  = 16;
    localparam int CODE_W  = 8;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 6;
    localparam int GLYPH_W = 7;
    localparam int FONT_W  = 8;
    localparam int XOFF_W  = 14;
    localparam int YOFF_W  = 13;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Register indexes on the configuration port (byte address / 4)
    typedef enum logic [1:0] {
        REG_ALTCHAR = 2'd0,
        REG_DOUBLE  = 2'd1,
        REG_FONT_W  = 2'd2,
        REG_FONT_H  = 2'd3
    } tcd_reg_t;

    localparam logic [FONT_W-1:0] FONT_W_RESET = 8'd7;
    localparam logic [FONT_W-1:0] FONT_H_RESET = 8'd8;

    localparam logic [COL_W:0]     LINE_CHARS   = 7'd40;
    localparam logic [GLYPH_W-1:0] GLYPH_DEL    = 7'h7F;
    localparam logic [GLYPH_W-1:0] GLYPH_SPACE  = 7'h20;

    typedef struct packed {
        logic               drawn;
        logic [ROW_W-1:0]   cell_row;
        logic [COL_W-1:0]   cell_col;
        logic [GLYPH_W-1:0] glyph;
        logic               inverse;
        logic [XOFF_W-1:0]  x_offset;
        logic [YOFF_W-1:0]  y_offset;
    } tcd_result_t;

    typedef struct packed {
        logic              altchar_mode;
        logic              double_video;
        logic [FONT_W-1:0] font_width;
        logic [FONT_W-1:0] font_height;
    } tcd_cfg_t;

endpackage

// ===== rtl/tcd_decode.sv =====
// Combinational decode of one text memory write into a screen cell.
`timescale 1ns / 1ps

module tcd_decode (
    input  logic [tcd_pkg::ADDR_W-1:0] mem_addr,
    input  logic [tcd_pkg::CODE_W-1:0] char_code,
    input  tcd_pkg::tcd_cfg_t          cfg,
    output tcd_pkg::tcd_result_t       result
);
    import tcd_pkg::*;

    logic               in_page1;
    logic               in_page2;
    logic               hole;
    logic               visible;
    logic [2:0]         group;
    logic [6:0]         slot;
    logic [1:0]         third;
    logic [6:0]         col_wide;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic               lower;
    logic [GLYPH_W-1:0] glyph;
    logic               inverse;
    logic [COL_W+FONT_W-1:0] x_prod;
    logic [ROW_W+FONT_W-1:0] y_prod;

    always_comb
    begin
        in_page1 = (mem_addr[15:12] == 4'h0) && (mem_addr[11:10] == 2'b01);
        in_page2 = (mem_addr[15:12] == 4'h0) && (mem_addr[11:10] == 2'b10);
        group    = mem_addr[9:7];
        slot     = mem_addr[6:0];
        // last eight slots of each group are not on screen
        hole     = (slot[6:3] == 4'hF);
        visible  = (in_page1 || (in_page2 && cfg.double_video)) && !hole;

        // slot below 120: split into thirds of 40 by compare and subtract
        if (slot >= {LINE_CHARS[5:0], 1'b0})
        begin
            third    = 2'd2;
            col_wide = slot - {LINE_CHARS[5:0], 1'b0};
        end
        else if (slot >= LINE_CHARS)
        begin
            third    = 2'd1;
            col_wide = slot - LINE_CHARS;
        end
        else
        begin
            third    = 2'd0;
            col_wide = slot;
        end
        col = col_wide[COL_W-1:0];
        row = {third, group};

        lower = (char_code[6:5] == 2'b11) && (cfg.altchar_mode || char_code[7]);
        if (lower)
            glyph = (char_code[6:0] == GLYPH_DEL) ? GLYPH_SPACE : char_code[6:0];
        else
            glyph = {~char_code[5], char_code[5:0]};

        inverse = (char_code[7:6] == 2'b00) ||
                  (cfg.altchar_mode && (char_code[7:5] == 3'b011) &&
                   (char_code[4:0] != 5'h1F));

        x_prod = col * cfg.font_width;
        y_prod = row * cfg.font_height;

        result = '0;
        if (visible)
        begin
            result.drawn    = 1'b1;
            result.cell_row = row;
            result.cell_col = col;
            result.glyph    = glyph;
            result.inverse  = inverse;
            result.x_offset = x_prod[XOFF_W-1:0];
            result.y_offset = y_prod[YOFF_W-1:0];
        end
    end

endmodule

// ===== rtl/text_cell_decode.sv =====
// Top level of the 40-column interleaved text cell decoder.
//
// Input channel: in_valid / in_stall carry one text memory write per beat
// (mem_addr, char_code). Output channel: out_valid / out_stall carry one
// result per beat (drawn, cell_row, cell_col, glyph, inverse, x_offset,
// y_offset). A beat moves at a rising edge with valid high and stall low.
// Each write gives exactly one result; writes off screen give drawn = 0
// with every other field 0.
// A beat taken into the input register goes through the decode to the
// result register. Throughput: one beat per cycle while out_stall is low;
// the input register takes a new write while a result waits.
// When the receiver stalls, the result holds and the input register fills;
// in_stall then rises until the result is taken.
// Configuration: APB port, registers at byte addresses 0 (altchar_mode),
// 4 (double_video), 8 (font_width), 12 (font_height); write only while idle.
// Reset clears the valid flags of both pipeline registers and loads the
// register defaults (primary set, page 2 off, 7 x 8 font).
`timescale 1ns / 1ps

module text_cell_decode (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcd_pkg::PADDR_W-1:0]   paddr,
    input  logic [tcd_pkg::PDATA_W-1:0]   pwdata,
    output logic [tcd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tcd_pkg::ADDR_W-1:0]    mem_addr,
    input  logic [tcd_pkg::CODE_W-1:0]    char_code,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          drawn,
    output logic [tcd_pkg::ROW_W-1:0]     cell_row,
    output logic [tcd_pkg::COL_W-1:0]     cell_col,
    output logic [tcd_pkg::GLYPH_W-1:0]   glyph,
    output logic                          inverse,
    output logic [tcd_pkg::XOFF_W-1:0]    x_offset,
    output logic [tcd_pkg::YOFF_W-1:0]    y_offset
);
    import tcd_pkg::*;

    tcd_cfg_t            cfg_reg;
    tcd_cfg_t            cfg_next;
    tcd_reg_t            reg_sel;
    logic                cfg_write;

    logic                in_valid_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [CODE_W-1:0]   code_reg;
    logic                out_valid_reg;
    tcd_result_t         result_reg;
    tcd_result_t         result_next;

    logic                out_open;
    logic                in_open;

    // Configuration port
    assign pready    = 1'b1;
    assign reg_sel   = tcd_reg_t'(paddr[PADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (reg_sel)
                REG_ALTCHAR: cfg_next.altchar_mode = pwdata[0];
                REG_DOUBLE:  cfg_next.double_video = pwdata[0];
                REG_FONT_W:  cfg_next.font_width   = pwdata[FONT_W-1:0];
                REG_FONT_H:  cfg_next.font_height  = pwdata[FONT_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_ALTCHAR: prdata = {{(PDATA_W-1){1'b0}}, cfg_reg.altchar_mode};
            REG_DOUBLE:  prdata = {{(PDATA_W-1){1'b0}}, cfg_reg.double_video};
            REG_FONT_W:  prdata = {{(PDATA_W-FONT_W){1'b0}}, cfg_reg.font_width};
            REG_FONT_H:  prdata = {{(PDATA_W-FONT_W){1'b0}}, cfg_reg.font_height};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.altchar_mode <= 1'b0;
            cfg_reg.double_video <= 1'b0;
            cfg_reg.font_width   <= FONT_W_RESET;
            cfg_reg.font_height  <= FONT_H_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Pipeline flow: result register opens when empty or taken,
    // input register opens when empty or draining into the result
    assign out_open = !out_valid_reg || !out_stall;
    assign in_open  = !in_valid_reg || out_open;
    assign in_stall = !in_open;

    tcd_decode u_decode (
        .mem_addr  (addr_reg),
        .char_code (code_reg),
        .cfg       (cfg_reg),
        .result    (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_open)
                in_valid_reg <= in_valid;
            if (out_open)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_open && in_valid)
        begin
            addr_reg <= mem_addr;
            code_reg <= char_code;
        end
        if (out_open && in_valid_reg)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign drawn     = result_reg.drawn;
    assign cell_row  = result_reg.cell_row;
    assign cell_col  = result_reg.cell_col;
    assign glyph     = result_reg.glyph;
    assign inverse   = result_reg.inverse;
    assign x_offset  = result_reg.x_offset;
    assign y_offset  = result_reg.y_offset;

    // Stall only with both registers full and the receiver holding off
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled while pipeline has room");

    // A drawn cell lies on the 40 x 24 screen
    a_cell_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && drawn) |-> ((cell_row < 5'd24) && (cell_col < 6'd40)))
        else $error("drawn cell outside the screen");

    // A cell that is not drawn carries an all-zero result
    a_blank_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !drawn) |-> ((cell_row == '0) && (cell_col == '0) &&
            (glyph == '0) && !inverse && (x_offset == '0) && (y_offset == '0)))
        else $error("undrawn result has nonzero fields");

    // A result that waits is overwritten only after it is taken
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(result_reg)))
        else $error("stalled result changed");

endmodule
